>>> src/rrt_pkg.sv
package rrt_pkg;

  localparam int MaxNodes = 1024;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);
  localparam int CoordW   = 16;
  localparam int StepW    = 15;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgRootX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRootY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStep  = 2'd2;

  localparam logic OpExtend = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Sample and node differences are exact in 17 bits; squared sums in 35.
  localparam int DiffW = 17;
  localparam int D2W   = 35;
  // r = isqrt(d2 << 16): radicand 51 bits, root 26 bits.
  localparam int RadW  = 52;
  localparam int RootW = 26;
  // Quotient numerator: step * |d| * 256 < 2^15 * 2^16 * 2^8.
  localparam int NumW  = 40;

  typedef enum logic [3:0] {
    DpIdle,
    DpClear,
    DpSearchStart,
    DpSearchStep,
    DpSteerStart,
    DpSqrtStep,
    DpDivXStart,
    DpDivStep,
    DpDivYStart,
    DpFinish
  } dp_cmd_e;

  typedef struct packed {
    logic search_done;
    logic sqrt_done;
    logic div_done;
  } dp_status_t;

endpackage

>>> src/rrt_tree_extend.sv
// channel | direction | handshake               | words
// in      | input     | in_valid_i / in_stall_o   | operation, sample_x, sample_y
// out     | output    | out_valid_o / out_stall_i | new_x, new_y, parent/node index, full
// cfg     | input     | cfg_we_i                  | root_x, root_y, step_length
//
// An extend makes one registered memory read per stored node, a 26-step square
// root and two 40-step restoring divisions. One word is in flight at a time.
// Reset leaves the tree holding the root alone; node memory is not cleared.
// A result is held while out_stall_i is high; input is stalled until it leaves.
module rrt_tree_extend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [15:0]            sample_x_i,
  input  logic signed [15:0]            sample_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            new_x_o,
  output logic signed [15:0]            new_y_o,
  output logic [9:0]                    parent_index_o,
  output logic [9:0]                    node_index_o,
  output logic                          tree_full_o,
  input  logic                          cfg_we_i,
  input  logic [rrt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrt_pkg::CfgDataW-1:0]  cfg_data_i
);

  rrt_pkg::dp_cmd_e    cmd;
  rrt_pkg::dp_status_t status;
  logic                is_clear;

  rrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .is_clear_i(is_clear), .status_i(status), .cmd_o(cmd)
  );

  rrt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .operation_i, .sample_x_i, .sample_y_i,
    .new_x_o, .new_y_o, .parent_index_o, .node_index_o, .tree_full_o,
    .is_clear_o(is_clear)
  );

endmodule

>>> src/rrt_ram.sv
module rrt_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/rrt_datapath.sv
module rrt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrt_pkg::dp_cmd_e                 cmd_i,
  output rrt_pkg::dp_status_t              status_o,
  input  logic                             cfg_we_i,
  input  logic [rrt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rrt_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             operation_i,
  input  logic signed [15:0]               sample_x_i,
  input  logic signed [15:0]               sample_y_i,
  output logic signed [15:0]               new_x_o,
  output logic signed [15:0]               new_y_o,
  output logic [9:0]                       parent_index_o,
  output logic [9:0]                       node_index_o,
  output logic                             tree_full_o,
  output logic                             is_clear_o
);

  logic signed [15:0] root_x_q, root_y_q;
  logic [rrt_pkg::StepW-1:0] step_q;
  logic [rrt_pkg::CntW-1:0] count_q;

  logic signed [15:0] sx_q, sy_q;
  logic op_q;

  // Search: the address counter leads the registered read, whose data lines up with cmp_idx_q.
  logic [rrt_pkg::CntW-1:0] raddr_q, cmp_idx_q;
  logic cmp_vld_q;
  logic [rrt_pkg::IdxW-1:0] best_q;
  logic [rrt_pkg::D2W-1:0] best_d2_q;
  logic signed [15:0] px_q, py_q;
  logic [15:0] rd_x, rd_y;

  // Steering registers.
  logic [rrt_pkg::RadW-1:0] rad_q;
  logic [rrt_pkg::RadW-1:0] res_q;
  logic [rrt_pkg::RadW-1:0] bit_q;
  logic [rrt_pkg::NumW-1:0] num_q, quo_q;
  logic [rrt_pkg::NumW+rrt_pkg::RootW-1:0] rem_q;
  logic [5:0] div_cnt_q;
  logic signed [rrt_pkg::DiffW-1:0] dx_q, dy_q;
  logic signed [17:0] offx_q;
  logic d2_zero_q;

  logic signed [15:0] new_x_q, new_y_q;
  logic [9:0] parent_q, node_q;
  logic full_q;

  logic we;
  logic [rrt_pkg::IdxW-1:0] waddr;
  logic signed [15:0] nx_sat, ny_sat;

  rrt_ram #(.Width(16), .Depth(rrt_pkg::MaxNodes)) u_ram_x (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(nx_sat),
    .raddr_i(raddr_q[rrt_pkg::IdxW-1:0]), .rdata_o(rd_x)
  );
  rrt_ram #(.Width(16), .Depth(rrt_pkg::MaxNodes)) u_ram_y (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(ny_sat),
    .raddr_i(raddr_q[rrt_pkg::IdxW-1:0]), .rdata_o(rd_y)
  );

  // Current candidate: root comes from the registers.
  logic signed [15:0] cx, cy;
  logic signed [rrt_pkg::DiffW-1:0] cdx, cdy;
  logic signed [2*rrt_pkg::DiffW-1:0] cdx2, cdy2;
  logic [rrt_pkg::D2W-1:0] cd2;
  assign cx   = (cmp_idx_q == '0) ? root_x_q : $signed(rd_x);
  assign cy   = (cmp_idx_q == '0) ? root_y_q : $signed(rd_y);
  assign cdx  = rrt_pkg::DiffW'(sx_q) - rrt_pkg::DiffW'(cx);
  assign cdy  = rrt_pkg::DiffW'(sy_q) - rrt_pkg::DiffW'(cy);
  assign cdx2 = cdx * cdx;
  assign cdy2 = cdy * cdy;
  assign cd2  = rrt_pkg::D2W'(cdx2) + rrt_pkg::D2W'(cdy2);

  logic full;
  assign full = (count_q == rrt_pkg::CntW'(rrt_pkg::MaxNodes));

  logic [rrt_pkg::D2W-1:0] pd2;
  logic signed [rrt_pkg::DiffW-1:0] pdx, pdy;
  assign pdx = rrt_pkg::DiffW'(sx_q) - rrt_pkg::DiffW'(px_q);
  assign pdy = rrt_pkg::DiffW'(sy_q) - rrt_pkg::DiffW'(py_q);
  assign pd2 = best_d2_q;

  // Square-root step.
  logic [rrt_pkg::RadW-1:0] trial;
  assign trial = rrt_pkg::RadW'(res_q) + bit_q;

  // Restoring divider, one quotient bit per cycle.
  logic [rrt_pkg::NumW+rrt_pkg::RootW-1:0] rem_sh;
  logic [rrt_pkg::NumW+rrt_pkg::RootW-1:0] div_sub;
  assign rem_sh  = {rem_q[rrt_pkg::NumW+rrt_pkg::RootW-2:0], num_q[rrt_pkg::NumW-1]};
  assign div_sub = rem_sh - (rrt_pkg::NumW+rrt_pkg::RootW)'(res_q);

  logic [rrt_pkg::DiffW-1:0] mag_x, mag_y;
  assign mag_x = dx_q[rrt_pkg::DiffW-1] ? rrt_pkg::DiffW'(-dx_q) : rrt_pkg::DiffW'(dx_q);
  assign mag_y = dy_q[rrt_pkg::DiffW-1] ? rrt_pkg::DiffW'(-dy_q) : rrt_pkg::DiffW'(dy_q);

  // Numerator with half the divisor folded in for rounding.
  logic [31:0] prod_x, prod_y;
  logic [rrt_pkg::NumW-1:0] num_x, num_y;
  assign prod_x = step_q * mag_x;
  assign prod_y = step_q * mag_y;
  assign num_x = rrt_pkg::NumW'({prod_x, 8'd0}) + rrt_pkg::NumW'(res_q >> 1);
  assign num_y = rrt_pkg::NumW'({prod_y, 8'd0}) + rrt_pkg::NumW'(res_q >> 1);

  logic signed [17:0] offy;
  logic signed [18:0] sum_x, sum_y;
  always_comb begin
    if (d2_zero_q) begin
      offy = '0;
    end else begin
      offy = dy_q[rrt_pkg::DiffW-1] ? -$signed({1'b0, quo_q[16:0]})
                                    :  $signed({1'b0, quo_q[16:0]});
    end
    sum_x = 19'(px_q) + 19'(offx_q);
    sum_y = 19'(py_q) + 19'(offy);
    nx_sat = (sum_x > 19'sd32767) ? 16'sh7fff :
             (sum_x < -19'sd32768) ? 16'sh8000 : sum_x[15:0];
    ny_sat = (sum_y > 19'sd32767) ? 16'sh7fff :
             (sum_y < -19'sd32768) ? 16'sh8000 : sum_y[15:0];
  end

  assign we    = (cmd_i == rrt_pkg::DpFinish) && !full;
  assign waddr = count_q[rrt_pkg::IdxW-1:0];

  assign status_o.search_done = !cmp_vld_q && (raddr_q >= count_q);
  assign status_o.sqrt_done   = (bit_q == '0);
  assign status_o.div_done    = (div_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_x_q <= 16'sd1280;
      root_y_q <= 16'sd1280;
      step_q   <= 15'd128;
      count_q  <= rrt_pkg::CntW'(1);
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rrt_pkg::CfgRootX: root_x_q <= $signed(cfg_data_i);
          rrt_pkg::CfgRootY: root_y_q <= $signed(cfg_data_i);
          rrt_pkg::CfgStep:  step_q   <= cfg_data_i[rrt_pkg::StepW-1:0];
          default: ;
        endcase
      end
      if (cmd_i == rrt_pkg::DpClear) begin
        count_q <= rrt_pkg::CntW'(1);
      end else if (we) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      rrt_pkg::DpIdle: begin
        sx_q <= sample_x_i;
        sy_q <= sample_y_i;
        op_q <= operation_i;
        cmp_vld_q <= 1'b0;
      end
      rrt_pkg::DpClear: begin
        new_x_q  <= root_x_q;
        new_y_q  <= root_y_q;
        parent_q <= '0;
        node_q   <= '0;
        full_q   <= 1'b0;
      end
      rrt_pkg::DpSearchStart: begin
        raddr_q   <= '0;
        cmp_vld_q <= 1'b0;
        best_q    <= '0;
        best_d2_q <= '0;
      end
      rrt_pkg::DpSearchStep: begin
        if (raddr_q < count_q) begin
          raddr_q   <= raddr_q + 1'b1;
          cmp_idx_q <= raddr_q;
          cmp_vld_q <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
        if (cmp_vld_q && (cmp_idx_q == '0 || cd2 < best_d2_q)) begin
          best_q    <= cmp_idx_q[rrt_pkg::IdxW-1:0];
          best_d2_q <= cd2;
          px_q      <= cx;
          py_q      <= cy;
        end
      end
      rrt_pkg::DpSteerStart: begin
        dx_q      <= pdx;
        dy_q      <= pdy;
        d2_zero_q <= (pd2 == '0);
        rad_q     <= {pd2, 16'd0} >> 0;
        res_q     <= '0;
        bit_q     <= rrt_pkg::RadW'(1) << (rrt_pkg::RadW - 2);
      end
      rrt_pkg::DpSqrtStep: begin
        if (bit_q != '0) begin
          if (rad_q >= trial) begin
            rad_q <= rad_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      rrt_pkg::DpDivXStart: begin
        num_q     <= num_x;
        rem_q     <= '0;
        quo_q     <= '0;
        div_cnt_q <= 6'(rrt_pkg::NumW);
      end
      rrt_pkg::DpDivYStart: begin
        offx_q    <= d2_zero_q ? 18'(step_q) :
                     (dx_q[rrt_pkg::DiffW-1] ? -$signed({1'b0, quo_q[16:0]})
                                             :  $signed({1'b0, quo_q[16:0]}));
        num_q     <= num_y;
        rem_q     <= '0;
        quo_q     <= '0;
        div_cnt_q <= 6'(rrt_pkg::NumW);
      end
      rrt_pkg::DpDivStep: begin
        if (div_cnt_q != '0) begin
          num_q <= num_q << 1;
          if (rem_sh >= (rrt_pkg::NumW+rrt_pkg::RootW)'(res_q)) begin
            rem_q <= div_sub;
            quo_q <= {quo_q[rrt_pkg::NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[rrt_pkg::NumW-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q - 1'b1;
        end
      end
      rrt_pkg::DpFinish: begin
        new_x_q  <= nx_sat;
        new_y_q  <= ny_sat;
        parent_q <= 10'(best_q);
        node_q   <= full ? 10'd0 : 10'(count_q);
        full_q   <= full;
      end
      default: ;
    endcase
  end

  assign new_x_o        = new_x_q;
  assign new_y_o        = new_y_q;
  assign parent_index_o = parent_q;
  assign node_index_o   = node_q;
  assign tree_full_o    = full_q;
  assign is_clear_o     = op_q;

endmodule

>>> src/rrt_ctrl.sv
module rrt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                is_clear_i,
  input  rrt_pkg::dp_status_t status_i,
  output rrt_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StDecode, StClear, StSearchStart, StSearch, StSteer, StSqrt,
    StDivX, StDivXRun, StDivY, StDivYRun, StFinish, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle:        if (in_valid_i) state_q <= StDecode;
        StDecode:      state_q <= is_clear_i ? StClear : StSearchStart;
        StClear: begin
          state_q     <= StOut;
          out_valid_q <= 1'b1;
        end
        StSearchStart: state_q <= StSearch;
        StSearch:      if (status_i.search_done) state_q <= StSteer;
        StSteer:       state_q <= StSqrt;
        StSqrt:        if (status_i.sqrt_done) state_q <= StDivX;
        StDivX:        state_q <= StDivXRun;
        StDivXRun:     if (status_i.div_done) state_q <= StDivY;
        StDivY:        state_q <= StDivYRun;
        StDivYRun:     if (status_i.div_done) state_q <= StFinish;
        StFinish: begin
          state_q     <= StOut;
          out_valid_q <= 1'b1;
        end
        StOut: begin
          // hold the word until taken
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      StIdle:        cmd_o = rrt_pkg::DpIdle;
      StClear:       cmd_o = rrt_pkg::DpClear;
      StSearchStart: cmd_o = rrt_pkg::DpSearchStart;
      StSearch:      cmd_o = rrt_pkg::DpSearchStep;
      StSteer:       cmd_o = rrt_pkg::DpSteerStart;
      StSqrt:        cmd_o = rrt_pkg::DpSqrtStep;
      StDivX:        cmd_o = rrt_pkg::DpDivXStart;
      StDivXRun:     cmd_o = rrt_pkg::DpDivStep;
      StDivY:        cmd_o = rrt_pkg::DpDivYStart;
      StDivYRun:     cmd_o = rrt_pkg::DpDivStep;
      StFinish:      cmd_o = rrt_pkg::DpFinish;
      default:       cmd_o = rrt_pkg::DpSearchStart;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule
